/* src/uer_pkg.sv */
// Shared types and constants for the three-channel echo ranger.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package uer_pkg;

  localparam int SENSOR_COUNT_DEF = 3;
  localparam int TIMER_BITS_DEF   = 16;

  localparam int STAMP_BITS  = 16;
  localparam int SENSOR_BITS = 2;
  localparam int DIST_BITS   = 9;

  localparam logic [SENSOR_BITS-1:0] NO_SENSOR      = 2'd3;
  localparam logic [DIST_BITS-1:0]   MAX_DIST_RESET = 9'd300;

  localparam int CM_DIVISOR   = 58;
  localparam int SAT_WIDTH    = CM_DIVISOR * (2 ** DIST_BITS);
  localparam int DIV_IN_BITS  = $clog2(SAT_WIDTH);
  localparam int RECIP_SHIFT  = 22;
  localparam int RECIP        = (2 ** RECIP_SHIFT + CM_DIVISOR - 1) / CM_DIVISOR;
  localparam int RECIP_BITS   = $clog2(RECIP + 1);
  localparam int PROD_BITS    = DIV_IN_BITS + RECIP_BITS;

  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_BITS = 1;
  localparam int Q_CNT_BITS = 2;

  typedef enum logic [1:0] {
    OP_BEGIN,
    OP_CAPTURE,
    OP_IGNORE
  } op_t;

  typedef struct packed {
    op_t                   op;
    logic [SENSOR_BITS-1:0] sensor;
    logic [STAMP_BITS-1:0]  stamp;
  } cmd_t;

  typedef struct packed {
    logic [DIST_BITS-1:0]   front_distance;
    logic [DIST_BITS-1:0]   left_distance;
    logic [DIST_BITS-1:0]   right_distance;
    logic                   front_valid;
    logic                   left_valid;
    logic                   right_valid;
    logic [SENSOR_BITS-1:0] trigger_request;
    logic                   measurement_done;
  } res_t;

endpackage

/* src/uer_front.sv */
// Front end: classifies each incoming word into a begin, capture or ignored command.
// Depends on uer_pkg.
`timescale 1ns / 1ps

module uer_front
  import uer_pkg::*;
#(
  parameter int SENSOR_COUNT = SENSOR_COUNT_DEF
) (
  input  logic                   action,
  input  logic [SENSOR_BITS-1:0] sensor,
  input  logic [STAMP_BITS-1:0]  timer_value,
  output cmd_t                   cmd
);

  logic known;

  always_comb begin
    known      = (int'(sensor) < SENSOR_COUNT) && (sensor != NO_SENSOR);
    cmd.sensor = sensor;
    cmd.stamp  = timer_value;
    if (!known) begin
      cmd.op = OP_IGNORE;
    end else if (action) begin
      cmd.op = OP_CAPTURE;
    end else begin
      cmd.op = OP_BEGIN;
    end
  end

endmodule

/* src/uer_cmd_queue.sv */
// Two-entry command queue between the front end and the execute stage.
// Depends on uer_pkg.
`timescale 1ns / 1ps

module uer_cmd_queue
  import uer_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  output logic full,
  input  cmd_t wr_data,
  input  logic pop,
  output logic empty,
  output cmd_t rd_data
);

  cmd_t                  q_r [Q_DEPTH];
  logic [Q_PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_BITS-1:0] count_r, count_nxt;
  logic                  do_push, do_pop;

  always_comb begin
    full       = (count_r == Q_CNT_BITS'(Q_DEPTH));
    empty      = (count_r == '0);
    do_push    = push && !full;
    do_pop     = pop && !empty;
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
    rd_data = q_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      q_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* src/uer_back.sv */
// Execute stage: per-sensor ranging state, width-to-distance conversion, limit
// register and the two-entry result queue. Depends on uer_pkg.
`timescale 1ns / 1ps

module uer_back
  import uer_pkg::*;
#(
  parameter int SENSOR_COUNT = SENSOR_COUNT_DEF,
  parameter int TIMER_BITS   = TIMER_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cmd_t                 cmd,
  input  logic                 cmd_empty,
  output logic                 cmd_pop,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [DIST_BITS-1:0] cfg_max_distance_cm,
  output res_t                 res,
  output logic                 res_empty,
  input  logic                 res_pop
);

  localparam int WW = (TIMER_BITS > STAMP_BITS) ? TIMER_BITS : STAMP_BITS;

  logic [TIMER_BITS-1:0]  rise_r     [SENSOR_COUNT];
  logic [TIMER_BITS-1:0]  rise_nxt   [SENSOR_COUNT];
  logic [DIST_BITS-1:0]   dist_r     [SENSOR_COUNT];
  logic [DIST_BITS-1:0]   dist_nxt   [SENSOR_COUNT];
  logic [SENSOR_COUNT-1:0] edge_r, edge_nxt;
  logic [SENSOR_COUNT-1:0] ready_r, ready_nxt;
  logic [SENSOR_BITS-1:0] active_r, active_nxt;
  logic [DIST_BITS-1:0]   max_r, max_nxt;

  logic [SENSOR_COUNT-1:0] hit;
  logic                    execute;
  logic [TIMER_BITS-1:0]   stamp;
  logic [TIMER_BITS-1:0]   rise_sel;
  logic                    edge_sel;
  logic [TIMER_BITS-1:0]   width;
  logic [WW-1:0]           width_w;
  logic [PROD_BITS-1:0]    prod;
  logic [DIST_BITS:0]      dist_raw;
  logic [DIST_BITS-1:0]    dist_cm;
  logic [SENSOR_BITS-1:0]  trig;
  logic                    done;

  logic [DIST_BITS-1:0]   dist_all  [3];
  logic [2:0]             ready_all;
  res_t                   res_new;

  res_t                  oq_r [Q_DEPTH];
  logic [Q_PTR_BITS-1:0] owr_r, owr_nxt;
  logic [Q_PTR_BITS-1:0] ord_r, ord_nxt;
  logic [Q_CNT_BITS-1:0] ocount_r, ocount_nxt;
  logic                  res_full, do_rpop;

  always_comb begin
    res_full = (ocount_r == Q_CNT_BITS'(Q_DEPTH));
    res_empty = (ocount_r == '0);
    execute  = !cmd_empty && !res_full;
    cmd_pop  = execute;
    do_rpop  = res_pop && !res_empty;
    cfg_ready = 1'b1;
    max_nxt  = cfg_valid ? cfg_max_distance_cm : max_r;

    stamp    = TIMER_BITS'(cmd.stamp);
    rise_sel = '0;
    edge_sel = 1'b0;
    for (int i = 0; i < SENSOR_COUNT; i++) begin
      hit[i] = (cmd.sensor == SENSOR_BITS'(i));
      if (hit[i]) begin
        rise_sel = rise_r[i];
        edge_sel = edge_r[i];
      end
    end

    width    = stamp - rise_sel;
    width_w  = WW'(width);
    prod     = PROD_BITS'(width_w[DIV_IN_BITS-1:0]) * PROD_BITS'(RECIP);
    if (width_w >= WW'(SAT_WIDTH)) begin
      dist_raw = {1'b1, {DIST_BITS{1'b0}}};
    end else begin
      dist_raw = {1'b0, prod[RECIP_SHIFT +: DIST_BITS]};
    end
    dist_cm = (dist_raw > {1'b0, max_r}) ? max_r : dist_raw[DIST_BITS-1:0];

    rise_nxt   = rise_r;
    dist_nxt   = dist_r;
    edge_nxt   = edge_r;
    ready_nxt  = ready_r;
    active_nxt = active_r;
    trig       = NO_SENSOR;
    done       = 1'b0;

    if (execute) begin
      case (cmd.op)
        OP_BEGIN: begin
          for (int i = 0; i < SENSOR_COUNT; i++) begin
            if (hit[i]) begin
              edge_nxt[i]  = 1'b0;
              ready_nxt[i] = 1'b0;
            end
          end
          active_nxt = cmd.sensor;
          trig       = cmd.sensor;
        end
        OP_CAPTURE: begin
          if (active_r == cmd.sensor) begin
            if (!edge_sel) begin
              for (int i = 0; i < SENSOR_COUNT; i++) begin
                if (hit[i]) begin
                  rise_nxt[i] = stamp;
                  edge_nxt[i] = 1'b1;
                end
              end
            end else begin
              for (int i = 0; i < SENSOR_COUNT; i++) begin
                if (hit[i]) begin
                  dist_nxt[i]  = dist_cm;
                  ready_nxt[i] = (dist_cm != '0);
                  edge_nxt[i]  = 1'b0;
                end
              end
              active_nxt = NO_SENSOR;
              done       = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_map
    if (g < SENSOR_COUNT) begin : g_present
      assign dist_all[g]  = dist_nxt[g];
      assign ready_all[g] = ready_nxt[g];
    end else begin : g_absent
      assign dist_all[g]  = '0;
      assign ready_all[g] = 1'b0;
    end
  end

  always_comb begin
    res_new.front_distance   = dist_all[0];
    res_new.left_distance    = dist_all[1];
    res_new.right_distance   = dist_all[2];
    res_new.front_valid      = ready_all[0];
    res_new.left_valid       = ready_all[1];
    res_new.right_valid      = ready_all[2];
    res_new.trigger_request  = trig;
    res_new.measurement_done = done;

    owr_nxt    = execute ? owr_r + 1'b1 : owr_r;
    ord_nxt    = do_rpop ? ord_r + 1'b1 : ord_r;
    ocount_nxt = ocount_r;
    if (execute && !do_rpop) begin
      ocount_nxt = ocount_r + 1'b1;
    end else if (do_rpop && !execute) begin
      ocount_nxt = ocount_r - 1'b1;
    end
    res = oq_r[ord_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SENSOR_COUNT; i++) begin
        rise_r[i] <= '0;
        dist_r[i] <= '0;
      end
      edge_r   <= '0;
      ready_r  <= '0;
      active_r <= NO_SENSOR;
      max_r    <= MAX_DIST_RESET;
      owr_r    <= '0;
      ord_r    <= '0;
      ocount_r <= '0;
    end else begin
      rise_r   <= rise_nxt;
      dist_r   <= dist_nxt;
      edge_r   <= edge_nxt;
      ready_r  <= ready_nxt;
      active_r <= active_nxt;
      max_r    <= max_nxt;
      owr_r    <= owr_nxt;
      ord_r    <= ord_nxt;
      ocount_r <= ocount_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (execute) begin
      oq_r[owr_r] <= res_new;
    end
  end

`ifndef SYNTHESIS
  a_active_known: assert property (@(posedge clk) disable iff (!rst_n)
    (active_r == NO_SENSOR) || (int'(active_r) < SENSOR_COUNT))
    else $error("active sensor holds an unknown number");

  a_done_clears_active: assert property (@(posedge clk) disable iff (!rst_n)
    (execute && done) |=> (active_r == NO_SENSOR))
    else $error("completed measurement left a sensor active");

  a_begin_arms: assert property (@(posedge clk) disable iff (!rst_n)
    (execute && cmd.op == OP_BEGIN) |=> (active_r == $past(cmd.sensor)))
    else $error("begin word did not arm its sensor");

  a_oq_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ocount_r <= Q_CNT_BITS'(Q_DEPTH))
    else $error("result queue count overflow");

  for (genvar g = 0; g < SENSOR_COUNT; g++) begin : g_chk
    a_ready_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
      ready_r[g] |-> (dist_r[g] != '0))
      else $error("valid reading with zero distance");
  end
`endif

endmodule

/* src/ultrasonic_echo_ranger_3ch.sv */
// A word accepted into the command queue is executed into the result queue, from which it can be popped.
// Throughput: one word per cycle while the result queue is not full, set by the execute stage
// (width subtract, reciprocal multiply by 1/58 and limit clamp).
// Reset: synchronous, active low; clears both queues, all sensor state, no sensor
// active, and the distance limit returns to 300. No clearing pass is needed.
`timescale 1ns / 1ps

module ultrasonic_echo_ranger_3ch
  import uer_pkg::*;
#(
  parameter int SENSOR_COUNT = SENSOR_COUNT_DEF,
  parameter int TIMER_BITS   = TIMER_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_push,
  output logic                   in_full,
  input  logic                   in_action,
  input  logic [SENSOR_BITS-1:0] in_sensor,
  input  logic [STAMP_BITS-1:0]  in_timer_value,
  output logic                   out_empty,
  input  logic                   out_pop,
  output logic [DIST_BITS-1:0]   out_front_distance,
  output logic [DIST_BITS-1:0]   out_left_distance,
  output logic [DIST_BITS-1:0]   out_right_distance,
  output logic                   out_front_valid,
  output logic                   out_left_valid,
  output logic                   out_right_valid,
  output logic [SENSOR_BITS-1:0] out_trigger_request,
  output logic                   out_measurement_done,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [DIST_BITS-1:0]   cfg_max_distance_cm
);

  cmd_t front_cmd;
  cmd_t head_cmd;
  logic cmd_empty;
  logic cmd_pop;
  res_t res;

  uer_front #(
    .SENSOR_COUNT(SENSOR_COUNT)
  ) u_front (
    .action      (in_action),
    .sensor      (in_sensor),
    .timer_value (in_timer_value),
    .cmd         (front_cmd)
  );

  uer_cmd_queue u_cmd_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push),
    .full    (in_full),
    .wr_data (front_cmd),
    .pop     (cmd_pop),
    .empty   (cmd_empty),
    .rd_data (head_cmd)
  );

  uer_back #(
    .SENSOR_COUNT(SENSOR_COUNT),
    .TIMER_BITS  (TIMER_BITS)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (head_cmd),
    .cmd_empty           (cmd_empty),
    .cmd_pop             (cmd_pop),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_max_distance_cm (cfg_max_distance_cm),
    .res                 (res),
    .res_empty           (out_empty),
    .res_pop             (out_pop)
  );

  assign out_front_distance   = res.front_distance;
  assign out_left_distance    = res.left_distance;
  assign out_right_distance   = res.right_distance;
  assign out_front_valid      = res.front_valid;
  assign out_left_valid       = res.left_valid;
  assign out_right_valid      = res.right_valid;
  assign out_trigger_request  = res.trigger_request;
  assign out_measurement_done = res.measurement_done;

endmodule
